// ===== design/szlm_pkg.sv =====
// ----------------------------------------------------------------------------
// szlm_pkg
// Shared widths for the depth-ordered sprite list: the fixed field widths of
// the request and response words.
// ----------------------------------------------------------------------------
package szlm_pkg;

  // Request word fields.
  localparam int unsigned SID_W = 8;
  localparam int unsigned DEP_W = 16;

  // Response word fields.
  localparam int unsigned POS_W = 6;
  localparam int unsigned CNT_W = 7;

endpackage

// ===== design/szlm_in_if.sv =====
// ----------------------------------------------------------------------------
// szlm_in_if
// Request channel: a sprite identifier and its new depth, valid/ready.
// ----------------------------------------------------------------------------
interface szlm_in_if;
  import szlm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [SID_W-1:0]        sprite_id;
  logic signed [DEP_W-1:0] new_depth;

  modport source (output valid, output sprite_id, output new_depth, input ready);
  modport sink (input valid, input sprite_id, input new_depth, output ready);
endinterface

// ===== design/szlm_out_if.sv =====
// ----------------------------------------------------------------------------
// szlm_out_if
// Response channel: insert slot, entry count and status flags, valid/ready.
// ----------------------------------------------------------------------------
interface szlm_out_if;
  import szlm_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] insert_position;
  logic [CNT_W-1:0] entry_count;
  logic             was_present;
  logic             dropped;

  modport source (output valid, output insert_position, output entry_count,
                  output was_present, output dropped, input ready);
  modport sink (input valid, input insert_position, input entry_count,
                input was_present, input dropped, output ready);
endinterface

// ===== design/szlm_table.sv =====
// ----------------------------------------------------------------------------
// szlm_table
// Two banks of (sprite, depth) entries in one memory. The scan reads the
// current bank and writes the rebuilt list into the other bank. One write
// port and one read port with registered read data.
// ----------------------------------------------------------------------------
module szlm_table #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rd_en_i,
  input  logic                                 rd_bank_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       rd_addr_i,
  output logic [ID_BITS-1:0]                   rd_id_o,
  output logic signed [szlm_pkg::DEP_W-1:0]    rd_depth_o,
  input  logic                                 wr_en_i,
  input  logic                                 wr_bank_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       wr_addr_i,
  input  logic [ID_BITS-1:0]                   wr_id_i,
  input  logic signed [szlm_pkg::DEP_W-1:0]    wr_depth_i
);
  import szlm_pkg::*;

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned MEM_N = 2 ** (AW + 1);

  logic [ID_BITS-1:0]        mem_id    [MEM_N];
  logic signed [DEP_W-1:0]   mem_depth [MEM_N];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_id[{wr_bank_i, wr_addr_i}]    <= wr_id_i;
      mem_depth[{wr_bank_i, wr_addr_i}] <= wr_depth_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_id_o    <= mem_id[{rd_bank_i, rd_addr_i}];
      rd_depth_o <= mem_depth[{rd_bank_i, rd_addr_i}];
    end
  end

endmodule

// ===== design/sorted_z_order_list_move.sv =====
// ----------------------------------------------------------------------------
// sorted_z_order_list_move
// Depth-ordered sprite list. Each request moves one sprite to a new depth,
// keeping the list sorted by descending depth.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req_i (sprite_id, new_depth) and each produces exactly
// one response word on rsp_o (insert_position, entry_count, was_present,
// dropped). A request is taken only while the block is idle.
// The sequencer streams the current list out of one memory bank, one entry
// per cycle except while the new entry is written, and writes the rebuilt
// list into the other bank: the old entry of the sprite is skipped and the
// new one is written in front of the first entry whose depth is not greater.
// The banks swap when the item completes. If the table is full and the
// sprite is new, the rebuilt bank is discarded. The scan goes through the
// single read port. A new request is taken only after the sequencer has
// loaded the response word of the previous one.
// The response sits in an output register, so the next request is accepted
// while it waits; a stalled receiver holds the next result in the sequencer.
// Reset empties the list at once; the memory contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_z_order_list_move #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  szlm_in_if.sink     req_i,
  szlm_out_if.source  rsp_o
);
  import szlm_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                  state_q;
  logic                    bank_q;
  logic [CW-1:0]           count_q;
  logic [CW-1:0]           rd_ptr_q;
  logic [CW-1:0]           wr_ptr_q;
  logic [CW-1:0]           pos_q;
  logic                    rvalid_q;
  logic                    ins_done_q;
  logic                    present_q;
  logic [ID_BITS-1:0]      id_q;
  logic signed [DEP_W-1:0] depth_q;

  logic                    out_valid_q;
  logic [POS_W-1:0]        out_pos_q;
  logic [CNT_W-1:0]        out_cnt_q;
  logic                    out_pres_q;
  logic                    out_drop_q;

  logic [ID_BITS-1:0]      rd_id;
  logic signed [DEP_W-1:0] rd_depth;

  logic                    hit;
  logic                    ins_now;
  logic                    tail_ins;
  logic                    copy_now;
  logic                    issue;
  logic                    scan_end;
  logic                    wr_en;
  logic [ID_BITS-1:0]      wr_id;
  logic signed [DEP_W-1:0] wr_depth;
  logic                    drop;
  logic                    slot_free;
  logic                    rsp_load;

  // Entry table with two banks.
  szlm_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rd_en_i    (issue),
    .rd_bank_i  (bank_q),
    .rd_addr_i  (rd_ptr_q[AW-1:0]),
    .rd_id_o    (rd_id),
    .rd_depth_o (rd_depth),
    .wr_en_i    (wr_en),
    .wr_bank_i  (~bank_q),
    .wr_addr_i  (wr_ptr_q[AW-1:0]),
    .wr_id_i    (wr_id),
    .wr_depth_i (wr_depth)
  );

  // Scan decisions on the entry just read.
  always_comb begin
    hit      = rvalid_q && (rd_id == id_q);
    ins_now  = (state_q == ST_SCAN) && rvalid_q && !hit && !ins_done_q
               && (rd_depth <= depth_q);
    copy_now = (state_q == ST_SCAN) && rvalid_q && !hit && !ins_now;
    issue    = (state_q == ST_SCAN) && !ins_now && (rd_ptr_q < count_q);
    tail_ins = (state_q == ST_SCAN) && !rvalid_q && (rd_ptr_q == count_q)
               && !ins_done_q;
    scan_end = (state_q == ST_SCAN) && !rvalid_q && (rd_ptr_q == count_q)
               && ins_done_q;
    wr_en    = (ins_now || tail_ins || copy_now) && (wr_ptr_q < CW'(TABLE_DEPTH));
    wr_id    = (ins_now || tail_ins) ? id_q : rd_id;
    wr_depth = (ins_now || tail_ins) ? depth_q : rd_depth;
    drop     = !present_q && (count_q == CW'(TABLE_DEPTH));
    slot_free = !out_valid_q || rsp_o.ready;
    rsp_load = (state_q == ST_DONE) && slot_free;
  end

  // Sequencer and response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bank_q      <= 1'b0;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      pos_q       <= '0;
      rvalid_q    <= 1'b0;
      ins_done_q  <= 1'b0;
      present_q   <= 1'b0;
      id_q        <= '0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
      out_pos_q   <= '0;
      out_cnt_q   <= '0;
      out_pres_q  <= 1'b0;
      out_drop_q  <= 1'b0;
    end else begin
      // The response register empties when taken, unless a new word loads.
      if (out_valid_q && rsp_o.ready && !rsp_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            id_q       <= ID_BITS'(req_i.sprite_id);
            depth_q    <= req_i.new_depth;
            rd_ptr_q   <= '0;
            wr_ptr_q   <= '0;
            rvalid_q   <= 1'b0;
            ins_done_q <= 1'b0;
            present_q  <= 1'b0;
            state_q    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            rd_ptr_q <= rd_ptr_q + 1'b1;
          end
          // Held data stays valid while the new entry is written first.
          rvalid_q <= issue || ins_now;
          if (hit) begin
            present_q <= 1'b1;
          end
          if (ins_now || tail_ins) begin
            ins_done_q <= 1'b1;
            pos_q      <= wr_ptr_q;
          end
          if (ins_now || tail_ins || copy_now) begin
            wr_ptr_q <= wr_ptr_q + 1'b1;
          end
          if (scan_end) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_pres_q  <= present_q;
            out_drop_q  <= drop;
            if (drop) begin
              out_pos_q <= '0;
              out_cnt_q <= CNT_W'(count_q);
            end else begin
              out_pos_q <= POS_W'(pos_q);
              out_cnt_q <= CNT_W'(wr_ptr_q);
              count_q   <= wr_ptr_q;
              bank_q    <= ~bank_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Channel outputs.
  assign req_i.ready           = (state_q == ST_IDLE);
  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.insert_position = out_pos_q;
  assign rsp_o.entry_count     = out_cnt_q;
  assign rsp_o.was_present     = out_pres_q;
  assign rsp_o.dropped         = out_drop_q;

endmodule
